@@ hdl/pfa_pkg.sv @@
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int NUM_FRAMES  = 4096;
    localparam int PAGE_SHIFT  = 12;

    localparam int PAGE_W      = 12;
    localparam int CNT_W       = 13;
    localparam int FADDR_W     = 24;
    localparam int OP_W        = 2;

    localparam int WORD_W      = 64;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int MAP_DEPTH   = NUM_FRAMES / WORD_W;
    localparam int WADDR_W     = $clog2(MAP_DEPTH);

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESERVE  = 2'd2;

    localparam logic [CNT_W-1:0] PAGES_RESET = CNT_W'(NUM_FRAMES);

    typedef struct packed {
        logic cap;
        logic start;
        logic rd;
        logic eval;
        logic fin;
    } t_pfa_cmd;

    typedef struct packed {
        logic skip;
        logic done;
    } t_pfa_sts;

endpackage

@@ hdl/pfa_ram.sv @@
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pfa_ctrl.sv @@
`timescale 1ns / 1ps

module pfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    input  pfa_pkg::t_pfa_sts i_sts,
    output pfa_pkg::t_pfa_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_READ  = 5'b00100,
        S_EVAL  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_sts.skip ? S_FIN : S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.done ? S_FIN : S_READ;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

endmodule

@@ hdl/pfa_datapath.sv @@
`timescale 1ns / 1ps

module pfa_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pfa_pkg::CNT_W-1:0]         i_cfg_wdata,
    input  logic [pfa_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic [pfa_pkg::OP_W-1:0]          i_s_axis_tuser,
    output logic [pfa_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                              o_m_axis_tuser,
    input  pfa_pkg::t_pfa_cmd                 i_cmd,
    output pfa_pkg::t_pfa_sts                 o_sts
);

    localparam int PW = pfa_pkg::PAGE_W;
    localparam int CW = pfa_pkg::CNT_W;
    localparam int BW = pfa_pkg::BIT_W;
    localparam int WW = pfa_pkg::WORD_W;
    localparam int AW = pfa_pkg::WADDR_W;
    localparam logic [CW-1:0] NUM_CNT = CW'(pfa_pkg::NUM_FRAMES);

    logic [CW-1:0]                r_pages;
    logic [CW-1:0]                r_hint, n_hint;
    logic [pfa_pkg::OP_W-1:0]     r_op;
    logic [PW-1:0]                r_pg;
    logic [CW-1:0]                r_end;
    logic [PW-1:0]                r_lo, r_hi;
    logic [AW-1:0]                r_ptr;
    logic [pfa_pkg::MAP_DEPTH-1:0] r_valid;
    logic [PW-1:0]                r_res_page;
    logic                         r_res_oom;
    logic [PW-1:0]                r_o_page;
    logic [pfa_pkg::FADDR_W-1:0]  r_o_addr;
    logic                         r_o_oom;

    logic [CW-1:0] limit, stop, lim_m1, stop_m1;
    logic          alloc_empty, resv_empty;
    logic [PW-1:0] start_lo, start_hi;
    logic [WW-1:0] rd_data, word, mask, cand, wdata;
    logic          hit, at_last, we;
    logic [BW-1:0] idx;
    logic [PW-1:0] found;
    logic          is_alloc, is_release, is_reserve;
    logic          sts_skip, sts_done;

    assign is_alloc   = (r_op == pfa_pkg::OP_ALLOCATE);
    assign is_release = (r_op == pfa_pkg::OP_RELEASE);
    assign is_reserve = (r_op == pfa_pkg::OP_RESERVE);

    assign limit       = (r_pages > NUM_CNT) ? NUM_CNT : r_pages;
    assign stop        = (r_end > NUM_CNT) ? NUM_CNT : r_end;
    assign lim_m1      = limit - CW'(1);
    assign stop_m1     = stop - CW'(1);
    assign alloc_empty = (r_hint >= limit);
    assign resv_empty  = (stop <= {1'b0, r_pg});

    always_comb begin
        start_lo = r_pg;
        start_hi = r_pg;
        sts_skip = 1'b1;
        case (r_op)
            pfa_pkg::OP_ALLOCATE: begin
                start_lo = r_hint[PW-1:0];
                start_hi = lim_m1[PW-1:0];
                sts_skip = alloc_empty;
            end
            pfa_pkg::OP_RELEASE: begin
                sts_skip = 1'b0;
            end
            pfa_pkg::OP_RESERVE: begin
                start_hi = stop_m1[PW-1:0];
                sts_skip = resv_empty;
            end
            default: sts_skip = 1'b1;
        endcase
    end

    // word out of the map; a never-written word is all free
    assign word    = r_valid[r_ptr] ? rd_data : '0;
    assign at_last = (r_ptr == r_hi[PW-1:BW]);

    always_comb begin
        for (int b = 0; b < WW; b++) begin
            mask[b] = ((r_ptr != r_lo[PW-1:BW]) || (BW'(b) >= r_lo[BW-1:0])) &&
                      ((r_ptr != r_hi[PW-1:BW]) || (BW'(b) <= r_hi[BW-1:0]));
        end
    end

    assign cand = ~word & mask;
    assign hit  = |cand;

    always_comb begin
        idx = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            if (cand[b]) begin
                idx = BW'(b);
            end
        end
    end

    assign found = {r_ptr, idx};

    always_comb begin
        wdata    = word;
        sts_done = 1'b1;
        case (r_op)
            pfa_pkg::OP_ALLOCATE: begin
                wdata    = word | (WW'(1) << idx);
                sts_done = hit || at_last;
            end
            pfa_pkg::OP_RELEASE: begin
                wdata = word & ~mask;
            end
            pfa_pkg::OP_RESERVE: begin
                wdata    = word | mask;
                sts_done = at_last;
            end
            default: sts_done = 1'b1;
        endcase
    end

    assign o_sts = '{skip: sts_skip, done: sts_done};

    assign we = i_cmd.eval && (is_release || is_reserve || (is_alloc && hit));

    always_comb begin
        n_hint = r_hint;
        if (i_cmd.eval) begin
            if (is_alloc && hit) begin
                n_hint = CW'(found) + CW'(1);
            end else if (is_release && ({1'b0, r_pg} < r_hint)) begin
                n_hint = {1'b0, r_pg};
            end
        end
    end

    pfa_ram #(
        .WIDTH (WW),
        .DEPTH (pfa_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_ptr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages <= pfa_pkg::PAGES_RESET;
            r_hint  <= '0;
            r_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pages <= i_cfg_wdata;
            end
            r_hint <= n_hint;
            if (we) begin
                r_valid[r_ptr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op  <= i_s_axis_tuser;
            r_pg  <= i_s_axis_tdata[PW-1:0];
            r_end <= i_s_axis_tdata[PW+CW-1:PW];
        end
        if (i_cmd.start) begin
            r_lo       <= start_lo;
            r_hi       <= start_hi;
            r_ptr      <= start_lo[PW-1:BW];
            r_res_page <= '0;
            r_res_oom  <= is_alloc && alloc_empty;
        end
        if (i_cmd.eval) begin
            if (is_alloc && hit) begin
                r_res_page <= found;
            end else if (is_alloc && at_last) begin
                r_res_oom <= 1'b1;
            end
            if (!sts_done) begin
                r_ptr <= r_ptr + AW'(1);
            end
        end
        if (i_cmd.fin) begin
            r_o_page <= r_res_page;
            r_o_addr <= pfa_pkg::FADDR_W'({{pfa_pkg::FADDR_W{1'b0}}, r_res_page}
                                          << pfa_pkg::PAGE_SHIFT);
            r_o_oom  <= r_res_oom;
        end
    end

    assign o_m_axis_tdata = {{(pfa_pkg::OUT_TDATA_W - PW - pfa_pkg::FADDR_W){1'b0}},
                             r_o_addr, r_o_page};
    assign o_m_axis_tuser = r_o_oom;

endmodule

@@ hdl/physical_frame_allocator.sv @@
`timescale 1ns / 1ps

// Page frame allocator over a one-bit-per-frame used map with a next-fit
// search hint. One request beat in, one result beat out. Allocate reads the
// map one 64-frame word at a time from the hint up to the managed page count
// and reads no word when the hint already sits at the limit. Release is one
// read-modify-write; reserve reads and writes each map word that the range
// touches, and none for an empty range; the unused code reads no word. The
// search is a read-modify-write loop on the single map memory, whose read is
// registered. The map is free after reset with no clearing pass: a valid bit
// per map word makes an unwritten word read as all free. A finished result
// waits in an output register; the next request is taken once it is
// latched. A write to pages_in_use takes effect at once, so write it only
// while the block is idle.

module physical_frame_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pfa_pkg::CNT_W-1:0]           i_cfg_wdata,     // pages_in_use
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [pfa_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // start page, range_end
    input  logic [pfa_pkg::OP_W-1:0]            i_s_axis_tuser,  // operation
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [pfa_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,  // frame_page, frame_address
    output logic [0:0]                          o_m_axis_tuser   // status
);

    pfa_pkg::t_pfa_cmd cmd;
    pfa_pkg::t_pfa_sts sts;
    logic              oom;

    pfa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    pfa_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (oom),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

    assign o_m_axis_tuser = oom;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result latched over a pending beat");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken while busy");

    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("out-of-memory beat carries a frame");

endmodule
